// ===== rtl/sil_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted insertion list package
// Shared sizes, payload types and cell control types for the sorted list.
// ----------------------------------------------------------------------------
package sil_pkg;

    // Number of values the store can hold.
    localparam int CAPACITY = 64;

    // Widths derived from the capacity.
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int INDEX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Fixed payload widths of the channels.
    localparam int VALUE_W = 32;
    localparam int RANK_W  = 7;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [RANK_W-1:0]         rank_t;

    // Control that every cell receives from the chain.
    typedef struct packed {
        logic   insert;     // a value is written into the row this cycle
        logic   occupied;   // this cell holds a stored value
        logic   left_lt;    // left neighbor holds a value smaller than the new one
        logic   first;      // this cell is the head of the row
    } cell_ctrl_t;

    // Status that the chain reports to the top level.
    typedef struct packed {
        logic [CAPACITY-1:0] boundary;  // one-hot place where the new value lands
        logic [INDEX_W-1:0]  rank;      // encoded place of the new value
        logic                head_lt;   // head cell is smaller than the new value
        value_t              head_value;
    } chain_status_t;

endpackage

// ===== rtl/sil_if.sv =====
// ----------------------------------------------------------------------------
// Sorted insertion list channels
// Valid/ready channels for the input values and the insert results.
// ----------------------------------------------------------------------------
interface sil_in_if;
    logic                 valid;
    logic                 ready;
    sil_pkg::value_t      value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sil_out_if;
    logic                 valid;
    logic                 ready;
    sil_pkg::rank_t       rank;
    sil_pkg::rank_t       stored_count;
    logic                 dropped;
    sil_pkg::value_t      smallest;
    sil_pkg::value_t      largest;

    modport source (output valid, output rank, output stored_count, output dropped,
                    output smallest, output largest, input ready);
    modport sink   (input valid, input rank, input stored_count, input dropped,
                    input smallest, input largest, output ready);
endinterface

// ===== rtl/sil_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one stored value, compares it to the incoming value and either keeps
// it, takes the new value or takes its left neighbor's value.
// ----------------------------------------------------------------------------
module sil_cell (
    input  logic                clk,
    input  sil_pkg::cell_ctrl_t ctrl,
    input  sil_pkg::value_t     new_value,
    input  sil_pkg::value_t     left_value,
    output sil_pkg::value_t     value,
    output logic                lt
);

    sil_pkg::value_t value_reg;
    sil_pkg::value_t value_next;
    logic            take_new;

    // A stored value smaller than the new one stays in place.
    assign lt       = ctrl.occupied && (value_reg < new_value);
    assign take_new = ctrl.first || ctrl.left_lt;

    // Either the new value lands here or everything from here up moves right.
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert && !lt)
        begin
            value_next = take_new ? new_value : left_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== rtl/sil_chain.sv =====
// ----------------------------------------------------------------------------
// Sorted list cell row
// A row of compare-and-shift cells kept in ascending order, with the encoder
// that turns the insertion boundary into a rank.
// ----------------------------------------------------------------------------
module sil_chain (
    input  logic                       clk,
    input  logic                       insert,
    input  sil_pkg::value_t            new_value,
    input  logic [sil_pkg::COUNT_W-1:0] count,
    output sil_pkg::chain_status_t     status
);

    sil_pkg::value_t                 cell_value [sil_pkg::CAPACITY];
    logic [sil_pkg::CAPACITY-1:0]    cell_lt;
    sil_pkg::cell_ctrl_t             cell_ctrl  [sil_pkg::CAPACITY];
    logic [sil_pkg::CAPACITY-1:0]    boundary;
    logic [sil_pkg::INDEX_W-1:0]     rank;

    // Row of cells, each fed by its left neighbor.
    for (genvar i = 0; i < sil_pkg::CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign cell_ctrl[i].left_lt = 1'b0;
            assign cell_ctrl[i].first   = 1'b1;
            assign boundary[i]          = !cell_lt[i];

            sil_cell u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl[i]),
                .new_value  (new_value),
                .left_value (new_value),
                .value      (cell_value[i]),
                .lt         (cell_lt[i])
            );
        end
        else
        begin : g_body
            assign cell_ctrl[i].left_lt = cell_lt[i-1];
            assign cell_ctrl[i].first   = 1'b0;
            assign boundary[i]          = !cell_lt[i] && cell_lt[i-1];

            sil_cell u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl[i]),
                .new_value  (new_value),
                .left_value (cell_value[i-1]),
                .value      (cell_value[i]),
                .lt         (cell_lt[i])
            );
        end
        assign cell_ctrl[i].insert   = insert;
        assign cell_ctrl[i].occupied = sil_pkg::COUNT_W'(i) < count;
    end

    // One-hot to binary: OR together the indexes of the marked cell.
    always_comb
    begin
        rank = '0;
        for (int i = 0; i < sil_pkg::CAPACITY; i++)
        begin
            if (boundary[i])
            begin
                rank = rank | sil_pkg::INDEX_W'(i);
            end
        end
    end

    assign status.boundary   = boundary;
    assign status.rank       = rank;
    assign status.head_lt    = cell_lt[0];
    assign status.head_value = cell_value[0];

endmodule

// ===== rtl/sorted_insertion_list_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted insertion list unit
// Keeps signed values in ascending order in a row of shifting cells and
// reports the rank, count, smallest and largest value for every insert.
// ----------------------------------------------------------------------------
//
//  Channel   Modport  Direction  Payload
//  in_ch     sink     input      value
//  out_ch    source   output     rank, stored_count, dropped, smallest, largest
//
// Every transfer on in_ch gives exactly one transfer on out_ch. On an insert
// all cells compare and shift in parallel in the same cycle, and the result
// is held in an output register, so one value per cycle is accepted while
// out_ch keeps taking results. A stall on out_ch holds in_ch off only when
// the output register is full and not being drained. Reset empties the
// store at once; no clearing pass is needed.
//
module sorted_insertion_list_unit (
    input  logic             clk,
    input  logic             rst_n,
    sil_in_if.sink           in_ch,
    sil_out_if.source        out_ch
);

    logic [sil_pkg::COUNT_W-1:0] count_reg;
    logic [sil_pkg::COUNT_W-1:0] count_next;
    sil_pkg::value_t             largest_reg;
    sil_pkg::value_t             largest_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    sil_pkg::rank_t              rank_reg;
    sil_pkg::rank_t              rank_next;
    sil_pkg::rank_t              stored_count_reg;
    sil_pkg::rank_t              stored_count_next;
    logic                        dropped_reg;
    logic                        dropped_next;
    sil_pkg::value_t             smallest_reg;
    sil_pkg::value_t             smallest_next;
    sil_pkg::value_t             largest_out_reg;
    sil_pkg::value_t             largest_out_next;

    logic                        accept;
    logic                        full;
    logic                        empty;
    logic                        insert;
    sil_pkg::chain_status_t      status;

    // Handshake: take a value whenever the output register can be refilled.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign full        = count_reg == sil_pkg::COUNT_W'(sil_pkg::CAPACITY);
    assign empty       = count_reg == '0;
    assign insert      = accept && !full;

    sil_chain u_chain (
        .clk       (clk),
        .insert    (insert),
        .new_value (in_ch.value),
        .count     (count_reg),
        .status    (status)
    );

    // Count and running maximum of the store.
    always_comb
    begin
        count_next   = count_reg;
        largest_next = largest_reg;
        if (insert)
        begin
            count_next = count_reg + sil_pkg::COUNT_W'(1);
            if (empty || (in_ch.value > largest_reg))
            begin
                largest_next = in_ch.value;
            end
        end
    end

    // Result register contents.
    always_comb
    begin
        out_valid_next    = out_valid_reg;
        rank_next         = rank_reg;
        stored_count_next = stored_count_reg;
        dropped_next      = dropped_reg;
        smallest_next     = smallest_reg;
        largest_out_next  = largest_out_reg;
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next    = 1'b1;
            dropped_next      = full;
            stored_count_next = sil_pkg::RANK_W'(count_next);
            largest_out_next  = largest_next;
            if (full)
            begin
                rank_next     = '0;
                smallest_next = status.head_value;
            end
            else
            begin
                rank_next     = sil_pkg::RANK_W'(status.rank);
                smallest_next = status.head_lt ? status.head_value : in_ch.value;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        largest_reg      <= largest_next;
        rank_reg         <= rank_next;
        stored_count_reg <= stored_count_next;
        dropped_reg      <= dropped_next;
        smallest_reg     <= smallest_next;
        largest_out_reg  <= largest_out_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.rank         = rank_reg;
    assign out_ch.stored_count = stored_count_reg;
    assign out_ch.dropped      = dropped_reg;
    assign out_ch.smallest     = smallest_reg;
    assign out_ch.largest      = largest_out_reg;

    // The store never holds more than its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sil_pkg::COUNT_W'(sil_pkg::CAPACITY))
        else $error("store count beyond capacity");

    // An insert lands at exactly one place in the row.
    assert property (@(posedge clk) disable iff (!rst_n)
        insert |-> $onehot(status.boundary))
        else $error("insertion boundary is not unique");

    // A stored value raises the count by one at the next edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        insert |=> count_reg == $past(count_reg) + sil_pkg::COUNT_W'(1))
        else $error("count did not follow an insert");

    // A result always describes an ordered, non-empty store.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (smallest_reg <= largest_out_reg) && (count_reg != '0))
        else $error("result bounds out of order");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted insertion list testbench
// Drives signed values into the unit and checks every insert result against
// a local ordered store or, for directed rows, against a typed-in result. A
// short table of directed values goes first. Then random values follow, with
// repeats, extremes and small clustered values, until the store fills and
// later values are dropped. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_ITEMS   = 1084;
    localparam int DIRECTED_N     = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    // One insert result, field by field.
    typedef struct packed {
        sil_pkg::rank_t  rank;
        sil_pkg::rank_t  stored_count;
        logic            dropped;
        sil_pkg::value_t smallest;
        sil_pkg::value_t largest;
    } insert_result_t;

    // One stimulus row: the value and, where known up front, its result.
    typedef struct packed {
        sil_pkg::value_t value;
        logic            typed;
        insert_result_t  want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sil_in_if  in_ch ();
    sil_out_if out_ch ();

    sorted_insertion_list_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Local copy of the ordered store.
    sil_pkg::value_t held_values [sil_pkg::CAPACITY];
    int              held_count;

    stim_row_t       offered_rows [$];
    insert_result_t  pending_results [$];
    sil_pkg::value_t recent_values [$];
    stim_row_t       directed_rows [DIRECTED_N];

    int  failures;
    int  idle_cycles;
    int  cycle_count;
    int  accepted_inputs;
    int  stored_total;
    int  dropped_total;
    int  tie_total;
    int  results_seen;
    bit  stimulus_done;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Places one value in the local store and returns what the unit should report.
    function automatic insert_result_t insert_value(sil_pkg::value_t v);
        insert_result_t r;
        int             pos;
        int             i;
        r = '0;
        if (held_count >= sil_pkg::CAPACITY)
        begin
            r.dropped = 1'b1;
            dropped_total++;
        end
        else
        begin
            pos = 0;
            while (pos < held_count && held_values[pos] < v)
                pos++;
            if (pos < held_count && held_values[pos] == v)
                tie_total++;
            for (i = held_count; i > pos; i--)
                held_values[i] = held_values[i - 1];
            held_values[pos] = v;
            held_count++;
            stored_total++;
            r.rank = sil_pkg::rank_t'(pos);
        end
        r.stored_count = sil_pkg::rank_t'(held_count);
        r.smallest     = held_values[0];
        r.largest      = held_values[held_count - 1];
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long; none in quiet stretches.
    function automatic int pick_gap(bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Random value: repeats of recent values, small clustered values, extremes,
    // or anything at all.
    function automatic sil_pkg::value_t random_value();
        int roll;
        int near_zero;
        roll = $urandom_range(0, 99);
        if (roll < 15 && recent_values.size() > 0)
            return recent_values[$urandom_range(0, recent_values.size() - 1)];
        if (roll < 35)
        begin
            near_zero = int'($urandom_range(0, 8)) - 4;
            return sil_pkg::value_t'(near_zero);
        end
        if (roll < 45)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return 32'sh8000_0001;
                default: return 32'sh7fff_fffe;
            endcase
        end
        return sil_pkg::value_t'($urandom);
    endfunction

    task automatic check_field(string field, logic signed [31:0] want,
                               logic signed [31:0] got);
        if (got !== want)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endtask

    // Reset and the input side.
    initial
    begin
        stim_row_t row;
        int        gap;
        int        idx;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.value     <= '0;
        held_count      = 0;
        stimulus_done   = 1'b0;

        // Directed values; results typed in where they are plain to see.
        directed_rows = '{
            '{32'sh0000_0000, 1'b1, '{7'd0, 7'd1, 1'b0, 32'sh0000_0000, 32'sh0000_0000}},
            '{32'sh7fff_ffff, 1'b1, '{7'd1, 7'd2, 1'b0, 32'sh0000_0000, 32'sh7fff_ffff}},
            '{32'sh8000_0000, 1'b1, '{7'd0, 7'd3, 1'b0, 32'sh8000_0000, 32'sh7fff_ffff}},
            '{32'sh0000_0000, 1'b1, '{7'd1, 7'd4, 1'b0, 32'sh8000_0000, 32'sh7fff_ffff}},
            '{32'shffff_ffff, 1'b0, '0},
            '{32'sh7fff_ffff, 1'b0, '0},
            '{32'sh8000_0000, 1'b1, '{7'd0, 7'd7, 1'b0, 32'sh8000_0000, 32'sh7fff_ffff}},
            '{32'sh0000_0001, 1'b0, '0},
            '{32'shffff_fffe, 1'b0, '0},
            '{32'sh5555_5555, 1'b0, '0},
            '{32'shaaaa_aaaa, 1'b0, '0},
            '{32'sh7fff_fffe, 1'b0, '0},
            '{32'sh8000_0001, 1'b0, '0},
            '{32'sh0000_ffff, 1'b0, '0},
            '{32'shffff_0000, 1'b0, '0},
            '{32'sh0000_0000, 1'b0, '0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (idx = 0; idx < DIRECTED_N + RANDOM_ITEMS; idx++)
        begin
            if (idx < DIRECTED_N)
                row = directed_rows[idx];
            else
            begin
                row       = '0;
                row.value = random_value();
            end
            recent_values.push_back(row.value);
            if (recent_values.size() > 32)
                void'(recent_values.pop_front());

            // Hold valid low for a while, or keep it high straight into the next transfer.
            gap = pick_gap((idx / 100) % 4 == 3);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            offered_rows.push_back(row);
            in_ch.valid <= 1'b1;
            in_ch.value <= row.value;
            do
                @(posedge clk);
            while (!in_ch.ready);
        end
        in_ch.valid <= 1'b0;
        stimulus_done = 1'b1;

        // Let the last results drain, then keep the clock running for strays.
        while (pending_results.size() != 0 || offered_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Inserted %0d values: %0d stored, %0d dropped on a full store, %0d ties.",
                 accepted_inputs, stored_total, dropped_total, tie_total);
        $display("Checked %0d results with %0d mismatches.", results_seen, failures);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Result side: ready drops for random stretches, with quiet windows.
    initial
    begin
        int run;
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            run = $urandom_range(1, 20);
            out_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
            gap = pick_gap((cycle_count / 500) % 4 == 3);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Prediction on each input transfer, comparison on each output transfer.
    initial
    begin
        failures        = 0;
        idle_cycles     = 0;
        cycle_count     = 0;
        accepted_inputs = 0;
        stored_total    = 0;
        dropped_total   = 0;
        tie_total       = 0;
        results_seen    = 0;
    end

    always @(posedge clk)
    begin
        stim_row_t      row;
        insert_result_t want;
        insert_result_t predicted;
        if (rst_n)
        begin
            cycle_count++;
            idle_cycles++;

            if (in_ch.valid && in_ch.ready)
            begin
                idle_cycles = 0;
                accepted_inputs++;
                row       = offered_rows.pop_front();
                predicted = insert_value(row.value);
                pending_results.push_back(row.typed ? row.want : predicted);
            end

            if (out_ch.valid && out_ch.ready)
            begin
                idle_cycles = 0;
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    failures++;
                    $display("%0t: result with no insert waiting, rank %0d count %0d",
                             $time, out_ch.rank, out_ch.stored_count);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("rank", 32'(want.rank), 32'(out_ch.rank));
                    check_field("stored_count", 32'(want.stored_count),
                                32'(out_ch.stored_count));
                    check_field("dropped", 32'(want.dropped), 32'(out_ch.dropped));
                    check_field("smallest", want.smallest, out_ch.smallest);
                    check_field("largest", want.largest, out_ch.largest);
                end
            end

            // Watchdog: too long without any transfer.
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, pending_results.size());
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule
